// ===== src/speech_chip_command_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the speech chip command decoder.
// ----------------------------------------------------------------------------
`ifndef SPEECH_CHIP_COMMAND_DECODER_MACROS_SVH
`define SPEECH_CHIP_COMMAND_DECODER_MACROS_SVH

// same-cycle implication under reset
`define SCC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scc assertion failed");

// next-cycle implication under reset
`define SCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scc assertion failed");

`endif

// ===== src/scc_pkg.sv =====
// ----------------------------------------------------------------------------
// scc_pkg
// Types and constants shared by the command decoder modules.
// ----------------------------------------------------------------------------
package scc_pkg;

	localparam logic [15:0] DEVICE_PAGE = 16'h040A;

	localparam logic [1:0] EV_NONE  = 2'd0;
	localparam logic [1:0] EV_PLAY  = 2'd1;
	localparam logic [1:0] EV_RANGE = 2'd2;
	localparam logic [1:0] EV_RESET = 2'd3;

	localparam logic [1:0] CMD_OPTION = 2'd0;
	localparam logic [1:0] CMD_VOICE  = 2'd3;

	localparam logic CFG_ENABLE  = 1'b0;
	localparam logic CFG_SAMPLES = 1'b1;

	typedef struct packed {
		logic       half_vol;
		logic       standby;
		logic       dac_sel;
		logic [1:0] volume;
		logic [1:0] repeat_code;
		logic       smooth;
	} settings_t;

	typedef struct packed {
		logic [1:0] event_kind;
		logic [6:0] sample_index;
		logic [2:0] attenuation_steps;
		logic       half_volume;
		logic       standby_off;
		logic       dac_output;
		logic [1:0] repeat_mode;
		logic       smooth_on;
	} result_t;

	typedef struct packed {
		logic       enable;
		logic [6:0] sample_count;
	} cfg_t;

endpackage

// ===== src/scc_decode.sv =====
// ----------------------------------------------------------------------------
// scc_decode
// Holds the command phase and the option and voice settings, decodes one request per cycle while advance is high.
// ----------------------------------------------------------------------------
module scc_decode (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  scc_pkg::cfg_t      cfg,
	input  logic [15:0]        page,
	input  logic [6:0]         data,
	output scc_pkg::result_t   result
);
	import scc_pkg::*;

	settings_t  set_q;
	settings_t  set_d;
	logic       awaiting_q;
	logic       awaiting_d;
	logic       hit;
	logic [6:0] idx;
	logic [1:0] kind;
	logic [6:0] sample;

	assign hit = cfg.enable && (page == DEVICE_PAGE);
	assign idx = data - 7'd1;

	always_comb begin
		set_d      = set_q;
		awaiting_d = awaiting_q;
		kind       = EV_NONE;
		sample     = '0;
		if (hit) begin
			if (data == '0) begin
				set_d = '0;
				kind  = EV_RESET;
			end else if (!awaiting_q) begin
				case (data[6:5])
					CMD_OPTION: begin
						set_d.half_vol = set_q.half_vol | data[0];
						set_d.standby  = set_q.standby | data[2];
						set_d.dac_sel  = set_q.dac_sel | data[3];
					end
					CMD_VOICE: begin
						set_d.volume      = data[1:0];
						set_d.repeat_code = data[3:2];
						set_d.smooth      = data[4];
						awaiting_d        = 1'b1;
					end
					default: begin
					end
				endcase
			end else begin
				awaiting_d = 1'b0;
				if (idx < cfg.sample_count) begin
					kind   = EV_PLAY;
					sample = idx;
				end else begin
					kind = EV_RANGE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_q      <= '0;
			awaiting_q <= 1'b0;
		end else if (advance) begin
			set_q      <= set_d;
			awaiting_q <= awaiting_d;
		end
	end

	always_comb begin
		result.event_kind        = kind;
		result.sample_index      = sample;
		result.attenuation_steps = {2'b00, set_d.half_vol} + {1'b0, set_d.volume};
		result.half_volume       = set_d.half_vol;
		result.standby_off       = set_d.standby;
		result.dac_output        = set_d.dac_sel;
		result.repeat_mode       = set_d.repeat_code;
		result.smooth_on         = set_d.smooth;
	end

endmodule

// ===== src/scc_out_reg.sv =====
// ----------------------------------------------------------------------------
// scc_out_reg
// Result register with valid/ready handshake toward the consumer.
// ----------------------------------------------------------------------------
module scc_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  scc_pkg::result_t   res_in,
	input  logic               ready,
	output logic               valid,
	output scc_pkg::result_t   res_q
);
	import scc_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
		end else if (load) begin
			valid <= 1'b1;
		end else if (ready) begin
			valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

// ===== src/speech_chip_command_decoder.sv =====
// ----------------------------------------------------------------------------
// speech_chip_command_decoder
// Bus command decoder for a speech sample chip: filters device-page writes,
// tracks option and voice settings, and reports play, out-of-range and reset events.
// ----------------------------------------------------------------------------
// One result per accepted request. A request enters the input register, is
// decoded against the settings registers and, once the result register can
// take it, lands there; a new request is taken every cycle as long as the
// result register drains. Configuration writes (enable, sample count) take
// effect at the next edge and are meant to be issued while no request is in
// flight.
`include "speech_chip_command_decoder_macros.svh"

module speech_chip_command_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] bus_address,
	input  logic [7:0]  write_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  event_kind,
	output logic [6:0]  sample_index,
	output logic [2:0]  attenuation_steps,
	output logic        half_volume,
	output logic        standby_off,
	output logic        dac_output,
	output logic [1:0]  repeat_mode,
	output logic        smooth_on
);
	import scc_pkg::*;

	cfg_t        cfg_q;
	logic        valid_s1;
	logic [15:0] page_s1;
	logic [6:0]  data_s1;
	logic        advance;
	result_t     res_d;
	result_t     res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ENABLE:  cfg_q.enable       <= cfg_data[0];
				CFG_SAMPLES: cfg_q.sample_count <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			page_s1 <= bus_address[31:16];
			data_s1 <= write_data[6:0];
		end
	end

	scc_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.cfg     (cfg_q),
		.page    (page_s1),
		.data    (data_s1),
		.result  (res_d)
	);

	scc_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance),
		.res_in (res_d),
		.ready  (out_ready),
		.valid  (out_valid),
		.res_q  (res_q)
	);

	assign event_kind        = res_q.event_kind;
	assign sample_index      = res_q.sample_index;
	assign attenuation_steps = res_q.attenuation_steps;
	assign half_volume       = res_q.half_volume;
	assign standby_off       = res_q.standby_off;
	assign dac_output        = res_q.dac_output;
	assign repeat_mode       = res_q.repeat_mode;
	assign smooth_on         = res_q.smooth_on;

	`SCC_ASSERT_NOW(a_atten_range, clk, arst_n, out_valid, attenuation_steps <= 3'd4)
	`SCC_ASSERT_NOW(a_play_in_range, clk, arst_n, out_valid && event_kind == EV_PLAY, sample_index < cfg_q.sample_count)
	`SCC_ASSERT_NOW(a_index_zero, clk, arst_n, out_valid && event_kind != EV_PLAY, sample_index == 7'd0)
	`SCC_ASSERT_NEXT(a_stage_hold, clk, arst_n, valid_s1 && !advance, valid_s1)

endmodule
